@@ src/assert_macros.svh @@
// Assertion macros used by the port checker file.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define NCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define NCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define NCS_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ncs_pkg.sv @@
// Shared constants, word types and scan tag for the palette color search.
// No dependencies.
`default_nettype none
package ncs_pkg;

  localparam int PALETTE_DEPTH = 32;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int COMP_W        = 12;
  localparam int SQ_W          = 2 * COMP_W;
  localparam int DIST_W        = 26;
  localparam int ENTRY_W       = 5;
  localparam int SIZE_W        = 6;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [DIST_W-1:0] DIST_MAX = 26'd50307075;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // register index is paddr[2]
  localparam logic REG_SEARCH_SIZE = 1'b0;

  typedef struct packed {
    logic               cmd;
    logic [ENTRY_W-1:0] entry_index;
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
  } item_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] best_index;
    logic [DIST_W-1:0]  best_distance;
  } result_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage
`default_nettype wire

@@ src/ncs_palette_ram.sv @@
// Palette memory: one write port, one read port, registered read data.
// Depends on ncs_pkg.
`default_nettype none
module ncs_palette_ram import ncs_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  color_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output color_t           rd_data
);

  color_t mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/ncs_dist_unit.sv @@
// Distance unit: registered squared differences, then sum and running minimum.
// Depends on ncs_pkg.
`default_nettype none
module ncs_dist_unit import ncs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  color_t            color_in,
  input  color_t            entry,
  input  scan_tag_t         tag,
  output logic [IDX_W-1:0]  best_idx,
  output logic [DIST_W-1:0] best_dist,
  output logic              done
);

  color_t            color;
  logic [COMP_W-1:0] d_r, d_g, d_b;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  scan_tag_t         tag2;
  logic [DIST_W-1:0] sum;

  always_comb begin
    d_r = (color.red >= entry.red) ? color.red - entry.red : entry.red - color.red;
    d_g = (color.green >= entry.green) ? color.green - entry.green
                                       : entry.green - color.green;
    d_b = (color.blue >= entry.blue) ? color.blue - entry.blue : entry.blue - color.blue;
    sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      color <= color_in;
    end
    sq_r      <= SQ_W'(d_r) * SQ_W'(d_r);
    sq_g      <= SQ_W'(d_g) * SQ_W'(d_g);
    sq_b      <= SQ_W'(d_b) * SQ_W'(d_b);
    if (tag2.valid && (tag2.first || sum < best_dist)) begin
      best_idx  <= tag2.idx;
      best_dist <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
      done <= 1'b0;
    end else begin
      tag2 <= tag;
      done <= tag2.valid && tag2.last;
    end
  end

endmodule
`default_nettype wire

@@ src/nearest_palette_color_search.sv @@
// Lookup: scans n entries from acceptance to result valid, n = live entries (1..32).
// A new item is not taken until the lookup is done; the palette read port scans one entry per cycle.
// A result word still waiting to be taken holds the next lookup before its result.
// Write item: accepted with no result.
// Reset: control and search size (to 1) cleared; palette contents undefined until written.
`default_nettype none
module nearest_palette_color_search import ncs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t            state;
  logic [SIZE_W-1:0] search_size;
  logic [IDX_W-1:0]  last_idx, last_idx_next;
  logic [IDX_W-1:0]  cnt;
  scan_tag_t         tag0, tag1;
  logic              accept, wr_en, rd_en, lookup;
  color_t            color_in, rd_data;
  logic [IDX_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;
  logic              done;

  assign pready     = 1'b1;
  assign item_ready = (state == S_IDLE) && !rst;
  assign accept     = item_valid && item_ready;
  assign lookup     = accept && (item.cmd == CMD_LOOKUP);
  assign wr_en      = accept && (item.cmd == CMD_WRITE) && (int'(item.entry_index) < PALETTE_DEPTH);
  assign color_in   = '{red: item.red, green: item.green, blue: item.blue};
  assign rd_en      = (state == S_SCAN);

  always_comb begin
    if (search_size == '0) begin
      last_idx_next = '0;
    end else if (int'(search_size) > PALETTE_DEPTH) begin
      last_idx_next = IDX_W'(PALETTE_DEPTH - 1);
    end else begin
      last_idx_next = IDX_W'(search_size - 1'b1);
    end
    tag0.valid = rd_en;
    tag0.first = (cnt == '0);
    tag0.last  = (cnt == last_idx);
    tag0.idx   = cnt;
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SEARCH_SIZE) begin
      prdata = PDATA_W'(search_size);
    end
  end

  ncs_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(item.entry_index)),
    .wr_data (color_in),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  ncs_dist_unit u_dist (
    .clk       (clk),
    .rst       (rst),
    .load      (lookup),
    .color_in  (color_in),
    .entry     (rd_data),
    .tag       (tag1),
    .best_idx  (best_idx),
    .best_dist (best_dist),
    .done      (done)
  );

  always_ff @(posedge clk) begin
    if (lookup) begin
      last_idx <= last_idx_next;
    end
    if (state == S_DONE && (!result_valid || result_ready)) begin
      result.best_index    <= ENTRY_W'(best_idx);
      result.best_distance <= best_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      tag1         <= '0;
      result_valid <= 1'b0;
      search_size  <= SIZE_W'(1);
    end else begin
      tag1 <= tag0;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_SEARCH_SIZE) begin
        search_size <= pwdata[SIZE_W-1:0];
      end
      unique case (state)
        S_IDLE: begin
          if (lookup) begin
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == last_idx) begin
            state <= S_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          if (done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/ncs_checker.sv @@
// Port-level checker for the palette color search, bound to the top level.
// Depends on ncs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ncs_port_checker import ncs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input item_t              item,
  input logic               result_valid,
  input logic               result_ready,
  input result_t            result,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  `NCS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result word dropped or changed while stalled")
  `NCS_ASSERT_RST(a_reset_empty, rst, !result_valid, "result valid right after reset")
  `NCS_ASSERT_NEXT(a_lookup_busy, item_valid && item_ready && item.cmd == CMD_LOOKUP, !item_ready, "input open during a scan")
  `NCS_ASSERT_SAME(a_dist_range, result_valid, result.best_distance <= DIST_MAX, "distance out of range")

endmodule

bind nearest_palette_color_search ncs_port_checker u_ncs_checker (.*);
`default_nettype wire

@@ dv/ncs_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the palette color search: mirrors palette writes and the size
// register, predicts the nearest entry for each lookup word and compares. Uses ncs_pkg.
module ncs_checker import ncs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  item_t              item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  output int                 mismatches,
  output int                 pending,
  output int                 results_checked
);

  color_t            palette_mirror [PALETTE_DEPTH];
  logic [SIZE_W-1:0] size_mirror;
  result_t           nearest_q [$];
  int                miss_count = 0;
  int                checked = 0;

  function automatic int unsigned square_gap(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
    int unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic result_t nearest_entry(color_t c);
    int unsigned live;
    int unsigned gap_sum;
    int unsigned best_dist;
    int          i;
    result_t     r;
    if (size_mirror == 0) live = 1;
    else if (size_mirror > PALETTE_DEPTH) live = PALETTE_DEPTH;
    else live = size_mirror;
    best_dist = 0;
    r = '0;
    for (i = 0; i < live; i++) begin
      gap_sum = square_gap(c.red, palette_mirror[i].red)
              + square_gap(c.green, palette_mirror[i].green)
              + square_gap(c.blue, palette_mirror[i].blue);
      if (i == 0 || gap_sum < best_dist) begin
        best_dist = gap_sum;
        r.best_index = i[ENTRY_W-1:0];
      end
    end
    r.best_distance = best_dist[DIST_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    color_t  c;
    if (rst) begin
      size_mirror = 1;
      nearest_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (nearest_q.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("[%0t] result word with nothing expected: index %0d distance %0d",
                     $realtime, result.best_index, result.best_distance);
        end else begin
          want = nearest_q.pop_front();
          checked++;
          if (result.best_index !== want.best_index ||
              result.best_distance !== want.best_distance) begin
            miss_count++;
            if (miss_count <= 10)
              $display("[%0t] result mismatch: index exp %0d got %0d, distance exp %0d got %0d",
                       $realtime, want.best_index, result.best_index,
                       want.best_distance, result.best_distance);
          end
        end
      end
      if (item_valid && item_ready) begin
        c.red = item.red;
        c.green = item.green;
        c.blue = item.blue;
        if (item.cmd == CMD_WRITE) palette_mirror[item.entry_index] = c;
        else nearest_q.push_back(nearest_entry(c));
      end
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_SEARCH_SIZE) begin
        if (pwrite) begin
          size_mirror = pwdata[SIZE_W-1:0];
        end else if (prdata !== PDATA_W'(size_mirror)) begin
          miss_count++;
          if (miss_count <= 10)
            $display("[%0t] search size read mismatch: exp %0d got %0d",
                     $realtime, size_mirror, prdata);
        end
      end
    end
    mismatches <= miss_count;
    pending <= nearest_q.size();
    results_checked <= checked;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the palette color search bench: clock, reset, stimulus and verdict.
// Drives nearest_palette_color_search beside ncs_checker; uses ncs_pkg.
module tb_top;
  import ncs_pkg::*;

  localparam int   LIMIT_CYCLES = 600000;
  localparam int   DRAIN_CYCLES = PALETTE_DEPTH + 8;
  localparam int   HOLD_AT      = 150;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   PHASE_ITEMS  = 110;
  localparam logic REG_SPARE    = 1'b1;
  localparam logic [COMP_W-1:0] COMP_MAX = '1;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  item_t              item;
  logic               result_valid;
  logic               result_ready;
  result_t            result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic               pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;

  int mismatches;
  int pending;
  int results_checked;
  int cycles = 0;
  int results_taken = 0;
  int writes_sent = 0;
  int lookups_sent = 0;
  int settings_run = 0;
  int size_now = 1;
  bit send_bursty = 0;
  bit recv_bursty = 0;

  color_t                   known [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] written = '0;

  nearest_palette_color_search uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ncs_checker scoreboard (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .mismatches(mismatches), .pending(pending), .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    int gap;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = recv_bursty ? 0 : $urandom_range(0, 19);
      if (results_taken == HOLD_AT) gap = HOLD_CYCLES;
      if ($urandom_range(0, 39) == 0) recv_bursty = !recv_bursty;
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
      results_taken++;
    end
  end

  function automatic int live_of(int sz);
    if (sz == 0) return 1;
    if (sz > PALETTE_DEPTH) return PALETTE_DEPTH;
    return sz;
  endfunction

  function automatic color_t pick_color(int span);
    int     roll;
    int     k;
    color_t c;
    roll = $urandom_range(0, 9);
    k = $urandom_range(0, span - 1);
    if (roll < 2 && written[k]) begin
      c = known[k];
    end else if (roll == 2) begin
      c.red = $urandom_range(0, 1) ? COMP_MAX : '0;
      c.green = $urandom_range(0, 1) ? COMP_MAX : '0;
      c.blue = $urandom_range(0, 1) ? COMP_MAX : '0;
    end else begin
      c.red = COMP_W'($urandom_range(0, 4095));
      c.green = COMP_W'($urandom_range(0, 4095));
      c.blue = COMP_W'($urandom_range(0, 4095));
    end
    return c;
  endfunction

  task automatic issue(logic cmd, logic [ENTRY_W-1:0] idx, color_t c);
    int    gap;
    item_t w;
    w.cmd = cmd;
    w.entry_index = idx;
    w.red = c.red;
    w.green = c.green;
    w.blue = c.blue;
    if (cmd == CMD_WRITE) begin
      known[idx] = c;
      written[idx] = 1'b1;
    end
    gap = send_bursty ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 39) == 0) send_bursty = !send_bursty;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!(item_valid && item_ready));
    if (cmd == CMD_LOOKUP) lookups_sent++;
    else writes_sent++;
  endtask

  task automatic apb_access(logic wr, logic idx, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_search_size(int sz);
    drain();
    apb_access(1'b1, REG_SEARCH_SIZE, sz);
    apb_access(1'b0, REG_SEARCH_SIZE, '0);
    size_now = sz;
    settings_run++;
  endtask

  task automatic random_phase(int count);
    int     live;
    int     hole;
    int     i;
    color_t c;
    live = live_of(size_now);
    repeat (count) begin
      hole = -1;
      for (i = live - 1; i >= 0; i--)
        if (!written[i]) hole = i;
      if (hole < 0 && $urandom_range(0, 9) < 7) begin
        issue(CMD_LOOKUP, ENTRY_W'($urandom_range(0, 31)), pick_color(live));
      end else begin
        c = pick_color(PALETTE_DEPTH);
        issue(CMD_WRITE, ENTRY_W'((hole >= 0) ? hole : $urandom_range(0, 31)), c);
      end
    end
  endtask

  initial begin
    int sizes [10];
    int p;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value, then a write to a register that does not exist
    apb_access(1'b0, REG_SEARCH_SIZE, '0);
    apb_access(1'b1, REG_SPARE, '1);
    apb_access(1'b0, REG_SEARCH_SIZE, '0);

    issue(CMD_WRITE, 0, '{'0, '0, '0});
    issue(CMD_LOOKUP, 31, '{'0, '0, '0});
    issue(CMD_LOOKUP, 0, '{COMP_MAX, COMP_MAX, COMP_MAX});
    issue(CMD_LOOKUP, 21, '{COMP_MAX, 12'h000, 12'h0a5});
    issue(CMD_WRITE, 1, '{COMP_MAX, COMP_MAX, COMP_MAX});
    issue(CMD_WRITE, 2, '{COMP_MAX, COMP_MAX, COMP_MAX});
    issue(CMD_WRITE, 31, '{12'h555, 12'haaa, 12'hf0f});
    issue(CMD_WRITE, 3, '{12'h800, 12'h7ff, 12'h001});

    set_search_size(3);
    issue(CMD_LOOKUP, 0, '{COMP_MAX, COMP_MAX, COMP_MAX});
    issue(CMD_LOOKUP, 0, '{12'h800, 12'h800, 12'h800});
    issue(CMD_LOOKUP, 10, '{12'h7ff, 12'h7ff, 12'h7ff});
    issue(CMD_LOOKUP, 0, '{12'h001, 12'h000, 12'h000});

    set_search_size(0);
    issue(CMD_LOOKUP, 0, '{COMP_MAX, COMP_MAX, COMP_MAX});
    issue(CMD_WRITE, 4, '{12'h123, 12'h456, 12'h789});
    issue(CMD_WRITE, 5, '{'0, '0, '0});

    set_search_size(6);
    issue(CMD_LOOKUP, 0, '{12'h123, 12'h456, 12'h789});
    issue(CMD_LOOKUP, 0, '{'0, '0, '0});
    issue(CMD_LOOKUP, 0, '{12'h555, 12'haaa, 12'hf0f});

    sizes = '{32, 63, 33, 2, 31, 1, 16, 0, 0, 0};
    for (p = 7; p < 10; p++) sizes[p] = $urandom_range(1, 32);
    for (p = 0; p < 10; p++) begin
      set_search_size(sizes[p]);
      random_phase(PHASE_ITEMS);
    end

    drain();
    $display("covered %0d lookups and %0d palette writes over %0d size settings",
             lookups_sent, writes_sent, settings_run);
    $display("%0d result words checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
